FILE: hdl/nhrw_pkg.sv
// ----------------------------------------------------------------------------
// nhrw_pkg
// Field widths, table codes and result status codes for the route walk.
// ----------------------------------------------------------------------------
package nhrw_pkg;

    localparam int ID_W     = 5;
    localparam int HOP_W    = 4;
    localparam int TTL_IN_W = 6;
    localparam int ENTRY_W  = 5;
    localparam int STATUS_W = 3;

    localparam logic [ENTRY_W-1:0] NO_ROUTE = 5'h1F;
    localparam logic [ID_W-1:0]    COUNT_RESET = 5'd16;

    typedef enum logic [STATUS_W-1:0] {
        ST_DELIVERED = 3'd0,
        ST_BAD_SRC   = 3'd1,
        ST_BAD_DST   = 3'd2,
        ST_TTL_EXP   = 3'd3,
        ST_NO_ROUTE  = 3'd4
    } status_t;

endpackage

FILE: hdl/nhrw_ram.sv
// ----------------------------------------------------------------------------
// nhrw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nhrw_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/nhrw_walk.sv
// ----------------------------------------------------------------------------
// nhrw_walk
// Table sequencer: clearing pass, entry writes and the hop-by-hop walk.
// ----------------------------------------------------------------------------
module nhrw_walk
    import nhrw_pkg::*;
#(
    parameter int MAX_ROUTERS = 16,
    parameter int TTL_BITS    = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [ID_W-1:0]      router_count,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  logic [ID_W-1:0]      router_id,
    input  logic [ID_W-1:0]      destination,
    input  logic signed [ENTRY_W-1:0] entry_next_hop,
    input  logic [TTL_IN_W-1:0]  ttl_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [HOP_W-1:0]     hop_router,
    output logic                 last,
    output logic [STATUS_W-1:0]  status,
    output logic [TTL_IN_W-1:0]  ttl_left
);

    localparam int DEPTH = MAX_ROUTERS * MAX_ROUTERS;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int TTL_W = TTL_BITS;
    localparam logic [6:0]       MAX_L    = 7'(MAX_ROUTERS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_MUL  = IDX_W'(MAX_ROUTERS);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_FAIL  = 5'b00100,
        S_STEP  = 5'b01000,
        S_EVAL  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0]    clr_idx_reg, clr_idx_next;
    logic [ID_W-1:0]     cur_reg, cur_next;
    logic [ID_W-1:0]     dst_reg, dst_next;
    logic [TTL_W-1:0]    ttl_reg, ttl_next;
    status_t             fail_reg, fail_next;

    logic                out_valid_reg, out_valid_next;
    logic [HOP_W-1:0]    hop_router_reg;
    logic                last_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [TTL_IN_W-1:0] ttl_left_reg;

    logic                ram_we, ram_re;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

    logic                accept, out_free, emit;
    logic [ID_W-1:0]     e_hop;
    logic                e_last;
    status_t             e_status;
    logic [TTL_W-1:0]    e_ttl;
    logic                src_ok, dst_ok, wr_ok, route_ok;

    nhrw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign src_ok   = (router_id < router_count) && ({2'b00, router_id} < MAX_L);
    assign dst_ok   = (destination < router_count) && ({2'b00, destination} < MAX_L);
    assign wr_ok    = ({2'b00, router_id} < MAX_L) && ({2'b00, destination} < MAX_L);
    assign route_ok = !ram_rdata[ENTRY_W-1] && (ram_rdata < router_count)
                      && ({2'b00, ram_rdata} < MAX_L);

    assign ram_raddr = IDX_W'(cur_reg) * IDX_MUL + IDX_W'(dst_reg);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        cur_next     = cur_reg;
        dst_next     = dst_reg;
        ttl_next     = ttl_reg;
        fail_next    = fail_reg;
        ram_we       = 1'b0;
        ram_waddr    = IDX_W'(router_id) * IDX_MUL + IDX_W'(destination);
        ram_wdata    = entry_next_hop;
        ram_re       = 1'b0;
        emit         = 1'b0;
        e_hop        = cur_reg;
        e_last       = 1'b1;
        e_status     = ST_DELIVERED;
        e_ttl        = ttl_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = NO_ROUTE;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!mode)
                    begin
                        ram_we = wr_ok;
                    end
                    else
                    begin
                        cur_next = router_id;
                        dst_next = destination;
                        ttl_next = TTL_W'(ttl_in);
                        if (!src_ok)
                        begin
                            fail_next  = ST_BAD_SRC;
                            state_next = S_FAIL;
                        end
                        else if (!dst_ok)
                        begin
                            fail_next  = ST_BAD_DST;
                            state_next = S_FAIL;
                        end
                        else
                        begin
                            state_next = S_STEP;
                        end
                    end
                end
            end
            S_FAIL:
            begin
                e_hop    = '0;
                e_status = fail_reg;
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_STEP:
            begin
                if (cur_reg == dst_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (ttl_reg == '0)
                begin
                    e_status = ST_TTL_EXP;
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!route_ok)
                begin
                    e_status = ST_NO_ROUTE;
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    e_last = 1'b0;
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        ttl_next   = ttl_reg - 1'b1;
                        cur_next   = ram_rdata;
                        state_next = S_STEP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        dst_reg  <= dst_next;
        ttl_reg  <= ttl_next;
        fail_reg <= fail_next;
        if (emit)
        begin
            hop_router_reg <= e_hop[HOP_W-1:0];
            last_reg       <= e_last;
            status_reg     <= e_status;
            ttl_left_reg   <= TTL_IN_W'(e_ttl);
        end
    end

    assign out_valid  = out_valid_reg;
    assign hop_router = hop_router_reg;
    assign last       = last_reg;
    assign status     = status_reg;
    assign ttl_left   = ttl_left_reg;

`ifndef SYNTHESIS
    a_eval_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && $past(state_reg) != S_EVAL) |-> $past(state_reg) == S_STEP)
        else $error("table data evaluated without a read");

    a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> status == ST_DELIVERED)
        else $error("status set on a beat that is not last");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_IDLE))
        else $error("table write during a walk");

    a_no_emit_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !emit)
        else $error("input accepted while a result is produced");
`endif

endmodule

FILE: hdl/next_hop_route_walk.sv
// ----------------------------------------------------------------------------
// next_hop_route_walk
// Next-hop table with hop-by-hop packet forwarding under a TTL budget.
// ----------------------------------------------------------------------------
// After reset the table is swept to no route, one entry per cycle, over all
// MAX_ROUTERS*MAX_ROUTERS entries (256 by default); in_stall is high during the
// sweep, while configuration writes are taken at any time. Each hop of a
// forward reads the table RAM in the step state and then evaluates the entry
// in the eval state; a stalled output holds the walk. One packet is walked at
// a time; a new beat is taken while the last result still waits in the output
// register.
// ----------------------------------------------------------------------------
module next_hop_route_walk
    import nhrw_pkg::*;
#(
    parameter int MAX_ROUTERS = 16,
    parameter int TTL_BITS    = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ID_W-1:0]           cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      mode,
    input  logic [ID_W-1:0]           router_id,
    input  logic [ID_W-1:0]           destination,
    input  logic signed [ENTRY_W-1:0] entry_next_hop,
    input  logic [TTL_IN_W-1:0]       ttl_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [HOP_W-1:0]          hop_router,
    output logic                      last,
    output logic [STATUS_W-1:0]       status,
    output logic [TTL_IN_W-1:0]       ttl_left
);

    logic [ID_W-1:0] router_count_reg, router_count_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        router_count_next = router_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            router_count_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            router_count_reg <= COUNT_RESET;
        end
        else
        begin
            router_count_reg <= router_count_next;
        end
    end

    nhrw_walk #(
        .MAX_ROUTERS (MAX_ROUTERS),
        .TTL_BITS    (TTL_BITS)
    ) u_walk (
        .clk            (clk),
        .rst_n          (rst_n),
        .router_count   (router_count_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .router_id      (router_id),
        .destination    (destination),
        .entry_next_hop (entry_next_hop),
        .ttl_in         (ttl_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hop_router     (hop_router),
        .last           (last),
        .status         (status),
        .ttl_left       (ttl_left)
    );

endmodule

FILE: bench/tb_next_hop_route_walk.sv
// ----------------------------------------------------------------------------
// tb_next_hop_route_walk
// Self-checking bench for the next-hop route walk. A mirror of the next-hop
// table and the router count tracks every accepted write and predicts each
// hop result of every forwarded packet. Directed tests cover id checks, walk
// endings and router count extremes. Random traffic then builds routes and
// walks them under sender gaps and receiver stalls. A long output hold-off
// forces the block to back up into its input.
// ----------------------------------------------------------------------------
module tb_next_hop_route_walk;
    import nhrw_pkg::*;

    localparam int N_ROUTERS     = 16;
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 40;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic [HOP_W-1:0]    hop;
        logic                last;
        status_t             st;
        logic [TTL_IN_W-1:0] ttl;
    } hop_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [ID_W-1:0]           cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      mode = 1'b0;
    logic [ID_W-1:0]           router_id = '0;
    logic [ID_W-1:0]           destination = '0;
    logic signed [ENTRY_W-1:0] entry_next_hop = '0;
    logic [TTL_IN_W-1:0]       ttl_in = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [HOP_W-1:0]          hop_router;
    logic                      last;
    logic [STATUS_W-1:0]       status;
    logic [TTL_IN_W-1:0]       ttl_left;

    logic [ENTRY_W-1:0] next_hop_mirror [N_ROUTERS][N_ROUTERS];
    int                 router_count_mirror;
    hop_result_t        expected_hops[$];

    int  send_gap_pct = 0;
    int  stall_pct = 0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  idle_cycles = 0;
    int  mismatches = 0;
    int  hops_checked = 0;
    int  writes_sent = 0;
    int  walks_sent = 0;
    int  count_settings = 0;
    int  endings [5] = '{default: 0};

    next_hop_route_walk DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .router_id      (router_id),
        .destination    (destination),
        .entry_next_hop (entry_next_hop),
        .ttl_in         (ttl_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hop_router     (hop_router),
        .last           (last),
        .status         (status),
        .ttl_left       (ttl_left)
    );

    always #5 clk = ~clk;

    function automatic int usable_count();
        return (router_count_mirror > N_ROUTERS) ? N_ROUTERS : router_count_mirror;
    endfunction

    function automatic void push_hop(input logic [HOP_W-1:0] hop, input logic lst,
                                     input status_t st, input logic [TTL_IN_W-1:0] ttl);
        hop_result_t r;
        r.hop  = hop;
        r.last = lst;
        r.st   = st;
        r.ttl  = ttl;
        expected_hops = {expected_hops, r};
    endfunction

    function automatic void predict_walk(input logic [ID_W-1:0] src,
                                         input logic [ID_W-1:0] dst,
                                         input logic [TTL_IN_W-1:0] ttl);
        int                  n;
        logic [HOP_W-1:0]    cur;
        logic [TTL_IN_W-1:0] budget;
        logic [ENTRY_W-1:0]  nh;
        bit                  done;
        n = usable_count();
        if (src >= n)
            push_hop('0, 1'b1, ST_BAD_SRC, ttl);
        else if (dst >= n)
            push_hop('0, 1'b1, ST_BAD_DST, ttl);
        else
        begin
            cur    = src[HOP_W-1:0];
            budget = ttl;
            done   = 1'b0;
            while (!done)
            begin
                if ({1'b0, cur} == dst)
                begin
                    push_hop(cur, 1'b1, ST_DELIVERED, budget);
                    done = 1'b1;
                end
                else if (budget == 0)
                begin
                    push_hop(cur, 1'b1, ST_TTL_EXP, '0);
                    done = 1'b1;
                end
                else
                begin
                    nh = next_hop_mirror[cur][dst[HOP_W-1:0]];
                    if (nh[ENTRY_W-1] || nh >= n)
                    begin
                        push_hop(cur, 1'b1, ST_NO_ROUTE, budget);
                        done = 1'b1;
                    end
                    else
                    begin
                        push_hop(cur, 1'b0, ST_DELIVERED, budget);
                        budget = budget - 1'b1;
                        cur    = nh[HOP_W-1:0];
                    end
                end
            end
        end
    endfunction

    task automatic send_beat(input logic m, input logic [ID_W-1:0] rid,
                             input logic [ID_W-1:0] dst, input logic [ENTRY_W-1:0] nh,
                             input logic [TTL_IN_W-1:0] ttl);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        in_valid       <= 1'b1;
        mode           <= m;
        router_id      <= rid;
        destination    <= dst;
        entry_next_hop <= nh;
        ttl_in         <= ttl;
        do @(posedge clk); while (in_stall);
        if (m == 1'b0)
        begin
            writes_sent++;
            if (rid < N_ROUTERS && dst < N_ROUTERS)
                next_hop_mirror[rid[HOP_W-1:0]][dst[HOP_W-1:0]] = nh;
        end
        else
        begin
            walks_sent++;
            predict_walk(rid, dst, ttl);
        end
    endtask

    task automatic write_entry(input int rid, input int dst, input int nh);
        send_beat(1'b0, rid[ID_W-1:0], dst[ID_W-1:0], nh[ENTRY_W-1:0], TTL_IN_W'($urandom));
    endtask

    task automatic forward(input int src, input int dst, input int ttl);
        send_beat(1'b1, src[ID_W-1:0], dst[ID_W-1:0], ENTRY_W'($urandom), ttl[TTL_IN_W-1:0]);
    endtask

    // drain all pending results, then allow a trailing table write to finish
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_hops.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_router_count(input int value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value[ID_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        router_count_mirror = value;
        count_settings++;
    endtask

    task automatic test_id_checks();
        forward(0, 0, 0);
        forward(3, 5, 63);
        forward(16, 2, 1);
        forward(31, 31, 42);
        forward(2, 16, 7);
        forward(15, 31, 63);
    endtask

    task automatic test_route_walks();
        write_entry(0, 15, 5);
        write_entry(5, 15, 10);
        write_entry(10, 15, 15);
        write_entry(31, 15, 3);
        write_entry(0, 20, 1);
        forward(0, 15, 63);
        forward(0, 15, 2);
        forward(0, 15, 0);
        write_entry(5, 15, -16);
        forward(0, 15, 63);
        write_entry(3, 4, 15);
        write_entry(1, 2, 6);
        write_entry(6, 2, 1);
        forward(1, 2, 5);
    endtask

    task automatic test_router_count();
        set_router_count(0);
        forward(0, 0, 7);
        set_router_count(1);
        forward(0, 0, 0);
        forward(1, 0, 3);
        forward(0, 1, 3);
        set_router_count(11);
        forward(3, 4, 9);
        forward(11, 0, 1);
        set_router_count(31);
        forward(3, 4, 9);
    endtask

    task automatic test_random_traffic(input int gap, input int stall, input int count);
        int sent;
        int n;
        int pick;
        int len;
        int src;
        int dst;
        int cur;
        int nxt;
        int ttl;
        int nh;
        logic m;
        logic [ID_W-1:0] rid;
        send_gap_pct = gap;
        stall_pct    = stall;
        set_router_count(count);
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            n = usable_count();
            if (n < 1)
                n = 1;
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // lay down a chain toward one destination, then walk it
                len = $urandom_range(1, 5);
                dst = $urandom_range(0, n - 1);
                src = $urandom_range(0, n - 1);
                cur = src;
                for (int i = 0; i < len; i++)
                begin
                    nxt = (i == len - 1) ? dst : $urandom_range(0, n - 1);
                    write_entry(cur, dst, nxt);
                    cur = nxt;
                end
                if ($urandom_range(0, 3) == 0)
                    ttl = $urandom_range(0, len);
                else
                    ttl = $urandom_range(len, 63);
                forward(src, dst, ttl);
                sent += len + 1;
            end
            else if (pick < 60)
            begin
                nh = ($urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1) : $urandom;
                write_entry($urandom_range(0, n - 1), $urandom_range(0, n - 1), nh);
                sent++;
            end
            else if (pick < 88)
            begin
                ttl = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 63);
                forward($urandom_range(0, n - 1), $urandom_range(0, n - 1), ttl);
                sent++;
            end
            else
            begin
                m   = 1'($urandom);
                rid = ID_W'($urandom);
                dst = $urandom;
                send_beat(m, rid, dst[ID_W-1:0], ENTRY_W'($urandom), TTL_IN_W'($urandom));
                if (m || (rid < N_ROUTERS && dst[ID_W-1:0] < N_ROUTERS))
                    sent++;
            end
        end
    endtask

    task automatic test_output_backpressure();
        send_gap_pct = 0;
        stall_pct    = 0;
        set_router_count(16);
        write_entry(1, 12, 2);
        write_entry(2, 12, 1);
        hold_request = 1'b1;
        repeat (6) forward(1, 12, 63);
        forward(0, 15, 63);
    endtask

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        hop_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            hops_checked++;
            if (last && status < 5)
                endings[status]++;
            if (expected_hops.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected hop result: hop %0d last %0d status %0d ttl %0d",
                             hop_router, last, status, ttl_left);
            end
            else
            begin
                want = expected_hops.pop_front();
                if (hop_router !== want.hop || last !== want.last ||
                    status !== want.st || ttl_left !== want.ttl)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("mismatch: expected hop %0d last %0d status %0d ttl %0d",
                                 want.hop, want.last, want.st, want.ttl);
                        $display("          got      hop %0d last %0d status %0d ttl %0d",
                                 hop_router, last, status, ttl_left);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        for (int r = 0; r < N_ROUTERS; r++)
            for (int d = 0; d < N_ROUTERS; d++)
                next_hop_mirror[r][d] = NO_ROUTE;
        router_count_mirror = COUNT_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_id_checks();
        test_route_walks();
        test_router_count();
        test_random_traffic(19, 69, 31);
        test_random_traffic(69, 19, $urandom_range(2, 15));
        test_random_traffic(0, 0, 16);
        test_output_backpressure();

        settle();
        mismatches += expected_hops.size();
        $display("Run covered %0d table writes and %0d packet walks over %0d router counts",
                 writes_sent, walks_sent, count_settings);
        $display("%0d hops; ends: ok %0d, bad src %0d, bad dst %0d, ttl %0d, no route %0d",
                 hops_checked, endings[0], endings[1], endings[2], endings[3], endings[4]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
